// File: hdl/irbd_pkg.sv
// irbd_pkg: shared constants and types for the ir barrier deviation block
// no dependencies; imported by irbd_res_if, the divider, the top level and the bench
`timescale 1ns / 1ps
`default_nettype none

package irbd_pkg;

    localparam int REG_W     = 15;
    localparam int DEV_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [REG_W-1:0] SENS_RESET = 15'd4915;
    localparam logic [REG_W-1:0] CAL_RESET  = 15'd1638;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSITIVITY = 1'b0,
        CFG_CAL_LEVEL   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic done;
        logic sat;
    } t_div_stat;

endpackage

`default_nettype wire

// File: hdl/irbd_in_if.sv
// irbd_in_if: valid/ready channel carrying one measurement beat
// sample width follows SAMPLE_BITS; no package dependency
`timescale 1ns / 1ps
`default_nettype none

interface irbd_in_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] dark_sample;
    logic [SAMPLE_BITS-1:0] light_sample;
    logic                   force_calibrate;

    modport source (output valid, output dark_sample, output light_sample,
                    output force_calibrate, input ready);
    modport sink   (input valid, input dark_sample, input light_sample,
                    input force_calibrate, output ready);
endinterface

`default_nettype wire

// File: hdl/irbd_res_if.sv
// irbd_res_if: valid/ready channel carrying one result beat
// uses DEV_W from irbd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface irbd_res_if import irbd_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic signed [DEV_W-1:0] deviation;
    logic                    barrier;
    logic                    recalibrated;

    modport source (output valid, output deviation, output barrier,
                    output recalibrated, input ready);
    modport sink   (input valid, input deviation, input barrier,
                    input recalibrated, output ready);
endinterface

`default_nettype wire

// File: hdl/irbd_div.sv
// irbd_div: bit-serial restoring divider, one quotient bit per cycle
// computes floor(num * 2^FRAC_BITS / den) with overflow flag; uses irbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module irbd_div import irbd_pkg::*; #(
    parameter int SAMPLE_BITS = 10,
    parameter int FRAC_BITS   = 14
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [2*SAMPLE_BITS-1:0]   i_num,
    input  wire logic [2*SAMPLE_BITS-1:0]   i_den,
    output t_div_stat                       o_stat,
    output logic      [FRAC_BITS+1:0]       o_quot
);
    localparam int PW    = 2 * SAMPLE_BITS;
    localparam int QW    = FRAC_BITS + 2;
    localparam int CNT_W = $clog2(QW);

    logic             r_busy;
    logic             r_done;
    logic             r_sat;
    logic [CNT_W-1:0] r_cnt;
    logic [PW-1:0]    r_rem;
    logic [PW-1:0]    r_den;
    logic [QW-1:0]    r_feed;
    logic [QW-1:0]    r_quot;

    logic [PW:0]      n_trial;
    logic [PW:0]      n_diff;
    logic             n_fits;
    logic             n_ovf;

    // quotient would need more than QW bits, or divisor is zero
    assign n_ovf   = (i_den == '0) || ({2'b00, i_num} >= {i_den, 2'b00});
    assign n_trial = {r_rem, r_feed[QW-1]};
    assign n_fits  = n_trial >= {1'b0, r_den};
    assign n_diff  = n_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den  <= i_den;
                // top bits of the dividend go straight in, they stay below den
                r_rem  <= PW'(i_num[PW-1:2]);
                r_feed <= {i_num[1:0], {FRAC_BITS{1'b0}}};
                r_cnt  <= CNT_W'(QW - 1);
                r_sat  <= n_ovf;
                if (n_ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_quot <= {r_quot[QW-2:0], n_fits};
                r_rem  <= n_fits ? n_diff[PW-1:0] : n_trial[PW-1:0];
                r_feed <= {r_feed[QW-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.sat  = r_sat;
    assign o_quot      = r_quot;

endmodule

`default_nettype wire

// File: hdl/ir_barrier_deviation_autocal_unit.sv
// ir_barrier_deviation_autocal_unit: top level, sequencer, shared multiplier,
// baseline and result registers; uses irbd_pkg, irbd_in_if, irbd_res_if, irbd_div
//
// usage:
//   i_in carries one measurement beat (dark_sample, light_sample,
//   force_calibrate); o_res returns exactly one result beat per measurement
//   (deviation in signed Q2.FRAC_BITS, barrier, recalibrated).
//   i_cfg_we/i_cfg_idx/i_cfg_data write sensitivity (index 0) and
//   calibration_level (index 1); write them only while the block is idle.
// sequencing:
//   one measurement at a time. the shared multiplier forms the divisor,
//   the dividend and the drift bound in turn, then the bit-serial divider
//   gives one quotient bit per cycle, FRAC_BITS + 2 bits in all. the next
//   beat is taken once the result has gone into the output register and
//   the sequencer is back in idle; a zero divisor or a quotient of four or
//   more skips the divider loop.
// reset:
//   synchronous, active low; the baseline clears to uncalibrated and the
//   registers return to sensitivity 4915 and calibration_level 1638.
// stall:
//   a result waits in the output register; the block takes the next beat
//   meanwhile and holds its finished result until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module ir_barrier_deviation_autocal_unit import irbd_pkg::*; #(
    parameter int SAMPLE_BITS = 10,
    parameter int FRAC_BITS   = 14
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [REG_W-1:0]     i_cfg_data,
    irbd_in_if.sink                   i_in,
    irbd_res_if.source                o_res
);
    localparam int S    = SAMPLE_BITS;
    localparam int PW   = 2 * S;
    localparam int MW   = (S > REG_W) ? S : REG_W;
    localparam int QW   = FRAC_BITS + 2;
    localparam int DW   = (FRAC_BITS + 3 > DEV_W) ? FRAC_BITS + 3 : DEV_W;
    localparam int CALW = REG_W + S;
    localparam int CW   = (S + FRAC_BITS > CALW) ? S + FRAC_BITS : CALW;

    localparam logic [DW-1:0] DEV_ONE = DW'(1) << FRAC_BITS;
    localparam logic [DW-1:0] DEV_SAT = DW'(0) - (DEV_ONE << 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_DEN,
        S_MUL_NUM,
        S_MUL_CAL,
        S_DIV,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [REG_W-1:0] r_sens;
    logic [REG_W-1:0] r_cal_level;
    logic [S-1:0]     r_base_dark;
    logic [S-1:0]     r_base_light;
    logic [S-1:0]     r_dark;
    logic [S-1:0]     r_light;
    logic             r_force;
    logic             r_recal;
    logic [PW-1:0]    r_den;
    logic [PW-1:0]    r_num;
    logic [CALW-1:0]  r_cal_prod;

    logic             r_out_valid;
    logic [DEV_W-1:0] r_out_dev;
    logic             r_out_bar;
    logic             r_out_recal;

    logic [MW-1:0]    n_mul_a;
    logic [S-1:0]     n_mul_b;
    logic [MW+S-1:0]  n_prod;
    t_div_stat        div_stat;
    logic [QW-1:0]    div_quot;
    logic             n_sat;
    logic [DW-1:0]    n_dev;
    logic             n_barrier;
    logic [S-1:0]     n_diff;
    logic             n_drift;
    logic             n_out_free;
    logic             n_accept;

    // shared multiplier, operands picked by the sequencer step
    always_comb begin
        case (r_state)
            S_MUL_DEN: begin
                n_mul_a = MW'(r_base_light);
                n_mul_b = r_dark;
            end
            S_MUL_NUM: begin
                n_mul_a = MW'(r_light);
                n_mul_b = r_base_dark;
            end
            default: begin
                n_mul_a = MW'(r_cal_level);
                n_mul_b = r_base_dark;
            end
        endcase
    end
    assign n_prod = n_mul_a * n_mul_b;

    irbd_div #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MUL_CAL),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // quotient of three or more saturates too
    assign n_sat     = div_stat.sat || (div_quot[QW-1:QW-2] == 2'b11);
    assign n_dev     = n_sat ? DEV_SAT : DEV_ONE - DW'(div_quot);
    assign n_barrier = !r_force && ($signed(n_dev) > $signed(DW'(r_sens)));
    assign n_diff    = (r_base_dark > r_dark) ? r_base_dark - r_dark
                                              : r_dark - r_base_dark;
    assign n_drift   = !r_force && !n_barrier &&
                       ((CW'(n_diff) << FRAC_BITS) > CW'(r_cal_prod));

    assign n_out_free = !r_out_valid || o_res.ready;
    assign n_accept   = i_in.valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sens       <= SENS_RESET;
            r_cal_level  <= CAL_RESET;
            r_base_dark  <= '0;
            r_base_light <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SENSITIVITY: r_sens      <= i_cfg_data;
                    CFG_CAL_LEVEL:   r_cal_level <= i_cfg_data;
                    default:         r_sens      <= r_sens;
                endcase
            end

            // the done step loads the output register itself
            if (r_out_valid && o_res.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_dark  <= i_in.dark_sample;
                        r_light <= i_in.light_sample;
                        r_force <= i_in.force_calibrate;
                        // forced or uncalibrated: this pair becomes the baseline
                        if (i_in.force_calibrate || r_base_dark == '0) begin
                            r_base_dark  <= i_in.dark_sample;
                            r_base_light <= i_in.light_sample;
                            r_recal      <= 1'b1;
                        end else begin
                            r_recal <= 1'b0;
                        end
                        r_state <= S_MUL_DEN;
                    end
                end
                S_MUL_DEN: begin
                    r_den   <= PW'(n_prod);
                    r_state <= S_MUL_NUM;
                end
                S_MUL_NUM: begin
                    r_num   <= PW'(n_prod);
                    r_state <= S_MUL_CAL;
                end
                S_MUL_CAL: begin
                    r_cal_prod <= CALW'(n_prod);
                    r_state    <= S_DIV;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_out_dev   <= n_dev[DEV_W-1:0];
                        r_out_bar   <= n_barrier;
                        r_out_recal <= r_recal || n_drift;
                        r_out_valid <= 1'b1;
                        if (n_drift) begin
                            r_base_dark  <= r_dark;
                            r_base_light <= r_light;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.deviation    = $signed(r_out_dev);
    assign o_res.barrier      = r_out_bar;
    assign o_res.recalibrated = r_out_recal;

endmodule

`default_nettype wire

// File: dv/tb_ir_barrier_deviation_autocal_unit.sv
// tb_ir_barrier_deviation_autocal_unit: self-checking bench for the ir barrier deviation block
// predicts deviation, barrier and recalibration per beat; needs irbd_pkg, both channel interfaces
`timescale 1ns / 1ps

module tb_ir_barrier_deviation_autocal_unit;
    import irbd_pkg::*;

    localparam int     SAMPLE_BITS    = 10;
    localparam int     FRAC_BITS      = 14;
    localparam longint ONE_Q          = longint'(1) << FRAC_BITS;
    localparam longint DEV_FLOOR      = -2 * ONE_Q;
    localparam int     SETTLE_CYCLES  = FRAC_BITS + 10;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     MAX_IDLE       = 13;

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic signed [DEV_W-1:0] deviation;
        logic                    barrier;
        logic                    recalibrated;
    } t_result_beat;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [REG_W-1:0]     cfg_data;

    irbd_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) meas_if ();
    irbd_res_if                             res_if ();

    ir_barrier_deviation_autocal_unit #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (meas_if),
        .o_res     (res_if)
    );

    // predictor state
    t_sample          baseline_dark;
    t_sample          baseline_light;
    logic [REG_W-1:0] sens_reg;
    logic [REG_W-1:0] cal_reg;

    t_result_beat expected_results[$];
    int           fail_count    = 0;
    bit           tx_idle_on    = 1'b1;
    bit           rx_idle_on    = 1'b1;
    int           rx_hold_req   = 0;
    int           rx_stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result_beat predict_measurement(input t_sample dark,
                                                         input t_sample light,
                                                         input logic    force_cal);
        t_result_beat      r;
        longint unsigned   bd, bl, dk, lt, den, num, quo, diff;
        longint            dev;
        r.barrier      = 1'b0;
        r.recalibrated = 1'b0;
        if (force_cal || baseline_dark == '0) begin
            baseline_dark  = dark;
            baseline_light = light;
            r.recalibrated = 1'b1;
        end
        bd  = baseline_dark;
        bl  = baseline_light;
        dk  = dark;
        lt  = light;
        den = bl * dk;
        if (den == 0) begin
            dev = DEV_FLOOR;
        end else begin
            num = (lt * bd) << FRAC_BITS;
            quo = num / den;
            if (quo >= 3 * ONE_Q) dev = DEV_FLOOR;
            else dev = ONE_Q - longint'(quo);
        end
        r.deviation = dev[DEV_W-1:0];
        if (!force_cal) begin
            r.barrier = dev > longint'(sens_reg);
            diff = (bd > dk) ? (bd - dk) : (dk - bd);
            // ambient drift beyond calibration_level of the baseline
            if (!r.barrier && (diff << FRAC_BITS) > longint'(cal_reg) * bd) begin
                baseline_dark  = dark;
                baseline_light = light;
                r.recalibrated = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_sample extreme_sample();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return t_sample'(1);
            2:       return {{(SAMPLE_BITS-1){1'b1}}, 1'b0};
            3:       return '1;
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic next_random_measurement(output t_sample dark, output t_sample light,
                                           output logic force_cal);
        int pick, span, d, l, pct;
        pick      = $urandom_range(0, 99);
        force_cal = 1'b0;
        if (pick < 8 || baseline_dark == '0) begin
            dark      = t_sample'($urandom);
            light     = t_sample'($urandom);
            force_cal = 1'($urandom_range(0, 1));
        end else if (pick < 12) begin
            dark      = t_sample'($urandom);
            light     = t_sample'($urandom);
            force_cal = 1'b1;
        end else if (pick < 18) begin
            dark  = extreme_sample();
            light = extreme_sample();
        end else begin
            // ambient near the baseline, lit sample scaled from the baseline ratio
            span = int'(baseline_dark) / 8 + 1;
            d    = int'(baseline_dark) + int'($urandom_range(0, 2 * span)) - span;
            if (d < 1) d = 1;
            if (d > (1 << SAMPLE_BITS) - 1) d = (1 << SAMPLE_BITS) - 1;
            pct = ($urandom_range(0, 99) < 60) ? int'($urandom_range(85, 110))
                                               : int'($urandom_range(0, 100));
            l = (int'(baseline_light) * d * pct) / (int'(baseline_dark) * 100);
            if (l > (1 << SAMPLE_BITS) - 1) l = (1 << SAMPLE_BITS) - 1;
            dark  = d[SAMPLE_BITS-1:0];
            light = l[SAMPLE_BITS-1:0];
        end
    endtask

    task automatic send_measurement(input t_sample dark, input t_sample light,
                                    input logic force_cal);
        int gap;
        gap = tx_idle_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
        if (gap > 0) begin
            meas_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        meas_if.valid           <= 1'b1;
        meas_if.dark_sample     <= dark;
        meas_if.light_sample    <= light;
        meas_if.force_calibrate <= force_cal;
        @(posedge i_clk);
        while (!meas_if.ready) @(posedge i_clk);
        expected_results.push_back(predict_measurement(dark, light, force_cal));
    endtask

    task automatic send_random_batch(input int count);
        t_sample dark, light;
        logic    force_cal;
        repeat (count) begin
            next_random_measurement(dark, light, force_cal);
            send_measurement(dark, light, force_cal);
        end
    endtask

    task automatic wait_results_drained();
        meas_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [REG_W-1:0] sens, input logic [REG_W-1:0] cal);
        wait_results_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SENSITIVITY;
        cfg_data <= sens;
        @(posedge i_clk);
        cfg_idx  <= CFG_CAL_LEVEL;
        cfg_data <= cal;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        sens_reg = sens;
        cal_reg  = cal;
    endtask

    task automatic test_directed_cases();
        // dark of zero while uncalibrated: stays uncalibrated, zero divisor
        send_measurement(10'd0, 10'd500, 1'b0);
        send_measurement(10'd400, 10'd800, 1'b0);
        send_measurement(10'd400, 10'd800, 1'b0);
        // full light loss gives +1.0
        send_measurement(10'd400, 10'd0, 1'b0);
        send_measurement(10'd400, 10'd400, 1'b0);
        send_measurement(10'd400, 10'd1023, 1'b0);
        // huge ratio saturates, then drift re-baseline
        send_measurement(10'd1, 10'd1023, 1'b0);
        send_measurement(10'd1023, 10'd1023, 1'b0);
        send_measurement(10'd1, 10'd0, 1'b0);
        send_measurement(10'd1023, 10'd1023, 1'b1);
        send_measurement(10'd1023, 10'd1023, 1'b0);
        // dark drops to zero: saturates and re-baselines to uncalibrated
        send_measurement(10'd0, 10'd1023, 1'b0);
        send_measurement(10'd700, 10'd0, 1'b0);
        send_measurement(10'd700, 10'd300, 1'b0);
        send_measurement(10'd0, 10'd0, 1'b1);
        send_measurement(10'd512, 10'd512, 1'b1);
        // drift just inside and just beyond the default calibration level
        send_measurement(10'd563, 10'd563, 1'b0);
        send_measurement(10'd564, 10'd564, 1'b0);
        send_measurement(10'd564, 10'd1023, 1'b1);
        send_measurement(10'd682, 10'd1023, 1'b0);
        send_measurement(10'd341, 10'd682, 1'b0);
        // ratio of exactly three saturates, two gives -1.0
        send_measurement(10'd1, 10'd1, 1'b1);
        send_measurement(10'd1, 10'd3, 1'b0);
        send_measurement(10'd1, 10'd2, 1'b0);
    endtask

    task automatic test_register_settings();
        logic [REG_W-1:0] sens_set[7];
        logic [REG_W-1:0] cal_set[7];
        sens_set = '{15'd0, 15'd16384, 15'd0, 15'd16384, 15'd8192, 15'd0, 15'd0};
        cal_set  = '{15'd0, 15'd16384, 15'd16384, 15'd0, 15'd819, 15'd0, 15'd0};
        sens_set[5] = REG_W'($urandom_range(0, 16384));
        cal_set[5]  = REG_W'($urandom_range(0, 16384));
        sens_set[6] = SENS_RESET;
        cal_set[6]  = CAL_RESET;
        for (int i = 0; i < 7; i++) begin
            set_regs(sens_set[i], cal_set[i]);
            send_random_batch(40);
        end
    endtask

    task automatic test_backpressure();
        wait_results_drained();
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        rx_hold_req = 400;
        send_random_batch(30);
        wait_results_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        send_random_batch(40);
        wait_results_drained();
        send_random_batch(40);
    endtask

    task automatic test_random_traffic();
        for (int blk = 0; blk < 12; blk++) begin
            if (blk % 3 == 2)
                set_regs(REG_W'($urandom_range(1000, 9000)), REG_W'($urandom_range(200, 4000)));
            // some stretches run with no idling on one or both sides
            tx_idle_on = ($urandom_range(0, 2) != 0);
            rx_idle_on = ($urandom_range(0, 2) != 0);
            send_random_batch(100);
        end
    endtask

    // result side: per-beat stall, long hold on request, compare against oldest prediction
    always @(posedge i_clk) begin
        t_result_beat want;
        if (res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing outstanding: deviation %0d", res_if.deviation);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (res_if.deviation !== want.deviation) begin
                    $error("deviation: expected %0d, got %0d", want.deviation, res_if.deviation);
                    fail_count++;
                end
                if (res_if.barrier !== want.barrier) begin
                    $error("barrier: expected %0b, got %0b", want.barrier, res_if.barrier);
                    fail_count++;
                end
                if (res_if.recalibrated !== want.recalibrated) begin
                    $error("recalibrated: expected %0b, got %0b",
                           want.recalibrated, res_if.recalibrated);
                    fail_count++;
                end
            end
            rx_stall_left = rx_idle_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
        end
        if (rx_hold_req > 0) begin
            rx_stall_left += rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_stall_left > 0) begin
            res_if.ready <= 1'b0;
            rx_stall_left--;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // watchdog: cycles with no beat on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((meas_if.valid && meas_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("** ir_barrier_deviation_autocal_unit: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n                 <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_idx                 <= CFG_SENSITIVITY;
        cfg_data                <= '0;
        meas_if.valid           <= 1'b0;
        meas_if.dark_sample     <= '0;
        meas_if.light_sample    <= '0;
        meas_if.force_calibrate <= 1'b0;
        sens_reg       = SENS_RESET;
        cal_reg        = CAL_RESET;
        baseline_dark  = '0;
        baseline_light = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_register_settings();
        test_backpressure();
        test_pause_until_drained();
        test_random_traffic();

        wait_results_drained();
        if (fail_count == 0) begin
            $display("** ir_barrier_deviation_autocal_unit: PASSED **");
        end else begin
            $display("** ir_barrier_deviation_autocal_unit: FAILED **");
        end
        $finish;
    end

endmodule
